/* src/htc_pkg.sv */
// htc_pkg: shared widths, reset values, register indexes and types for the
// thermostat controller core. No dependencies.
`default_nettype none

package htc_pkg;

  localparam int unsigned ADC_W    = 8;
  localparam int unsigned SP_W     = 6;
  localparam int unsigned HYST_W   = 4;
  localparam int unsigned GAIN_W   = 9;
  localparam int unsigned HOLD_W   = 10;
  localparam int unsigned PERIOD_W = 8;
  localparam int unsigned TENS_W   = 6;
  localparam int unsigned UNITS_W  = 4;
  localparam int unsigned RAW_W    = 14;
  localparam int unsigned FILT_W   = 18;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 10;

  localparam logic [HYST_W-1:0]   HYST_RST   = 4'd1;
  localparam logic [GAIN_W-1:0]   GAIN_RST   = 9'd77;
  localparam logic [GAIN_W-1:0]   GAIN_MAX   = 9'd256;
  localparam logic [HOLD_W-1:0]   HOLD_RST   = 10'd300;
  localparam logic [PERIOD_W-1:0] PERIOD_RST = 8'd30;
  localparam logic [SP_W-1:0]     SP_MAX_RST = 6'd40;
  localparam logic [SP_W-1:0]     SP_RST     = 6'd22;
  localparam logic signed [RAW_W-1:0]  RAW_RST  = 14'sd352;
  localparam logic signed [FILT_W-1:0] FILT_RST = 18'sd5632;
  localparam logic signed [RAW_W-1:0]  RAW_OFS  = 14'sd832;
  localparam logic [4:0] ADC_SCALE = 5'd29;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HYST   = 3'd0,
    CFG_GAIN   = 3'd1,
    CFG_HOLD   = 3'd2,
    CFG_PERIOD = 3'd3,
    CFG_SP_MAX = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [TENS_W-1:0]  tens;
    logic [UNITS_W-1:0] units;
    logic               minus;
  } tdig_t;

  typedef struct packed {
    logic               blank;
    logic [TENS_W-1:0]  tens;
    logic [UNITS_W-1:0] units;
    logic               minus;
    logic               setp;
  } disp_t;

  localparam tdig_t TDIG_RST = '{tens: 6'd2, units: 4'd2, minus: 1'b0};
  localparam disp_t DISP_BLANK = '{blank: 1'b1, tens: '0, units: '0, minus: 1'b0,
                                   setp: 1'b0};

  // tens and units of a 9-bit value (0 to 511) via multiply by 205 / 2048
  function automatic tdig_t split_dec(input logic [8:0] val);
    logic [16:0]        prod;
    logic [TENS_W-1:0]  tens;
    logic [9:0]         tens_x10;
    tdig_t              res;
    prod     = {8'd0, val} * 17'd205;
    tens     = prod[16:11];
    tens_x10 = {tens, 3'b000} + {3'b000, tens, 1'b0};
    res.tens  = tens;
    res.units = 4'(({1'b0, val} - tens_x10));
    res.minus = 1'b0;
    return res;
  endfunction

endpackage

`default_nettype wire

/* src/hysteresis_thermostat_controller_core.sv */
// Hysteresis thermostat controller core: power toggle, setpoint buttons,
// bang-bang relay with hysteresis, exponential filter and display selection.
// Depends on htc_pkg.
// Path: a taken transaction waits in the input register, goes through one
// pass of the step logic and lands in the result register.
// Throughput: one transaction per cycle unless a result is held by a low
// out_ready; the input register lets one more transaction in while a result waits for out_ready.
// Reset (synchronous, rst_n low): registers return to their defaults, heater
// off, setpoint 22, display blank, filter at 22 degrees, both channels empty.
`default_nettype none

module hysteresis_thermostat_controller_core (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [htc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [htc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic                            in_power_button,
  input  wire logic                            in_up_button,
  input  wire logic                            in_down_button,
  input  wire logic [htc_pkg::ADC_W-1:0]       in_adc_sample,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic                                 out_relay_on,
  output logic                                 out_heater_enabled,
  output logic                                 out_display_blank,
  output logic [htc_pkg::TENS_W-1:0]           out_display_tens,
  output logic [htc_pkg::UNITS_W-1:0]          out_display_units,
  output logic                                 out_display_minus,
  output logic                                 out_showing_setpoint,
  output logic                                 out_beep
);
  import htc_pkg::*;

  // configuration
  logic [HYST_W-1:0]   hyst_r;
  logic [GAIN_W-1:0]   gain_r;
  logic [HOLD_W-1:0]   hold_ticks_r;
  logic [PERIOD_W-1:0] period_r;
  logic [SP_W-1:0]     sp_max_r;

  // input register
  logic               in_v_r;
  logic               pw_r, up_r, dn_r;
  logic [ADC_W-1:0]   adc_r;

  // controller state
  logic                      mode_r, mode_nxt;
  logic [SP_W-1:0]           setpoint_r, setpoint_nxt;
  logic                      relay_r, relay_nxt;
  logic [HOLD_W-1:0]         hold_cnt_r, hold_cnt_nxt;
  logic [PERIOD_W-1:0]       sample_cnt_r, sample_cnt_nxt;
  logic signed [RAW_W-1:0]   raw_r, raw_nxt;
  logic signed [FILT_W-1:0]  filt_r, filt_nxt;
  tdig_t                     tdig_r, tdig_nxt;
  disp_t                     shown_r, shown_nxt;
  logic                      pf_power_r, pf_power_nxt;
  logic                      pf_up_r, pf_up_nxt;
  logic                      pf_down_r, pf_down_nxt;
  logic                      beep_nxt;

  // result register
  logic    out_valid_r;
  logic    out_relay_r, out_mode_r, out_beep_r;
  disp_t   out_disp_r;

  logic    adv;

  // datapath
  logic [GAIN_W-1:0]          gain_sat;
  logic [12:0]                adc_x29;
  logic signed [RAW_W-1:0]    raw_new;
  logic signed [18:0]         diff;
  logic signed [28:0]         prod;
  logic signed [20:0]         filt_sum;
  logic signed [FILT_W-1:0]   filt_new;
  logic [FILT_W-1:0]          filt_neg;
  logic [9:0]                 neg_mag;
  tdig_t                      sp_dig;
  logic signed [7:0]          sp_lo, sp_hi;
  logic signed [14:0]         thr_lo, thr_hi, raw_ext;

  assign adv      = in_v_r && (!out_valid_r || out_ready);
  assign in_ready = !in_v_r || adv;

  // sample conversion and filter update
  assign gain_sat = (gain_r > GAIN_MAX) ? GAIN_MAX : gain_r;
  assign adc_x29  = {5'd0, adc_r} * {8'd0, ADC_SCALE};
  assign raw_new  = $signed({1'b0, adc_x29}) - RAW_OFS;
  assign diff     = $signed({raw_new[RAW_W-1], raw_new, 4'b0000})
                  - $signed({filt_r[FILT_W-1], filt_r});
  assign prod     = diff * $signed({1'b0, gain_sat});
  // arithmetic shift of the product floors toward minus infinity
  assign filt_sum = $signed({{3{filt_r[FILT_W-1]}}, filt_r}) + prod[28:8];
  assign filt_new = filt_sum[FILT_W-1:0];

  // temperature digits follow the stored filter value; below -9 they hold
  assign filt_neg = -filt_r;
  assign neg_mag  = filt_neg[17:8];
  always_comb begin
    tdig_nxt = tdig_r;
    if (!filt_r[FILT_W-1]) begin
      tdig_nxt = split_dec(filt_r[16:8]);
    end else if (neg_mag == 10'd0) begin
      tdig_nxt = '{tens: '0, units: '0, minus: 1'b0};
    end else if (neg_mag <= 10'd9) begin
      tdig_nxt = '{tens: '0, units: neg_mag[3:0], minus: 1'b1};
    end
  end

  assign sp_dig  = split_dec({3'b000, setpoint_r});
  assign sp_lo   = $signed({2'b00, setpoint_r}) - $signed({4'b0000, hyst_r});
  assign sp_hi   = $signed({2'b00, setpoint_r}) + $signed({4'b0000, hyst_r});
  assign thr_lo  = $signed({{3{sp_lo[7]}}, sp_lo, 4'b0000});
  assign thr_hi  = $signed({{3{sp_hi[7]}}, sp_hi, 4'b0000});
  assign raw_ext = $signed({raw_r[RAW_W-1], raw_r});

  // one tick of the controller
  always_comb begin
    mode_nxt       = mode_r;
    setpoint_nxt   = setpoint_r;
    relay_nxt      = relay_r;
    hold_cnt_nxt   = hold_cnt_r;
    sample_cnt_nxt = sample_cnt_r;
    raw_nxt        = raw_r;
    filt_nxt       = filt_r;
    shown_nxt      = shown_r;
    pf_power_nxt   = pf_power_r;
    pf_up_nxt      = pf_up_r;
    pf_down_nxt    = pf_down_r;
    beep_nxt       = 1'b0;
    if (mode_r) begin
      if (hold_cnt_r < hold_ticks_r) begin
        shown_nxt    = '{blank: 1'b0, tens: sp_dig.tens, units: sp_dig.units,
                         minus: 1'b0, setp: 1'b1};
        hold_cnt_nxt = hold_cnt_r + 1'b1;
      end else if (!pf_up_r && !pf_down_r) begin
        shown_nxt = '{blank: 1'b0, tens: tdig_nxt.tens, units: tdig_nxt.units,
                      minus: tdig_nxt.minus, setp: 1'b0};
      end

      if (raw_ext < thr_lo) begin
        relay_nxt = 1'b1;
      end else if (raw_ext > thr_hi) begin
        relay_nxt = 1'b0;
      end

      if (sample_cnt_r < period_r) begin
        sample_cnt_nxt = sample_cnt_r + 1'b1;
      end else begin
        raw_nxt        = raw_new;
        filt_nxt       = filt_new;
        sample_cnt_nxt = '0;
        pf_up_nxt      = 1'b0;
        pf_down_nxt    = 1'b0;
      end

      // an up press at the limit still counts as a press
      if (up_r && !pf_up_nxt) begin
        if (setpoint_nxt < sp_max_r) begin
          setpoint_nxt = setpoint_nxt + 1'b1;
        end
        beep_nxt     = 1'b1;
        pf_up_nxt    = 1'b1;
        hold_cnt_nxt = '0;
      end else if (!up_r && pf_up_nxt) begin
        pf_up_nxt = 1'b0;
      end

      // a down press at zero is ignored altogether
      if (dn_r && !pf_down_nxt) begin
        if (setpoint_nxt != '0) begin
          setpoint_nxt = setpoint_nxt - 1'b1;
          beep_nxt     = 1'b1;
          pf_down_nxt  = 1'b1;
          hold_cnt_nxt = '0;
        end
      end else if (!dn_r && pf_down_nxt) begin
        pf_down_nxt = 1'b0;
      end

      if (pw_r && !pf_power_r) begin
        beep_nxt     = 1'b1;
        mode_nxt     = 1'b0;
        relay_nxt    = 1'b0;
        pf_power_nxt = 1'b1;
        shown_nxt    = DISP_BLANK;
      end else if (!pw_r && pf_power_r) begin
        pf_power_nxt = 1'b0;
      end
    end else begin
      if (pw_r && !pf_power_r) begin
        beep_nxt     = 1'b1;
        mode_nxt     = 1'b1;
        relay_nxt    = 1'b0;
        pf_power_nxt = 1'b1;
      end else if (!pw_r && pf_power_r) begin
        pf_power_nxt = 1'b0;
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hyst_r       <= HYST_RST;
      gain_r       <= GAIN_RST;
      hold_ticks_r <= HOLD_RST;
      period_r     <= PERIOD_RST;
      sp_max_r     <= SP_MAX_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_HYST:   hyst_r       <= cfg_data[HYST_W-1:0];
        CFG_GAIN:   gain_r       <= cfg_data[GAIN_W-1:0];
        CFG_HOLD:   hold_ticks_r <= cfg_data[HOLD_W-1:0];
        CFG_PERIOD: period_r     <= cfg_data[PERIOD_W-1:0];
        CFG_SP_MAX: sp_max_r     <= cfg_data[SP_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
    if (in_valid && in_ready) begin
      pw_r  <= in_power_button;
      up_r  <= in_up_button;
      dn_r  <= in_down_button;
      adc_r <= in_adc_sample;
    end
  end

  // controller state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= 1'b0;
      setpoint_r   <= SP_RST;
      relay_r      <= 1'b0;
      hold_cnt_r   <= '0;
      sample_cnt_r <= '0;
      raw_r        <= RAW_RST;
      filt_r       <= FILT_RST;
      tdig_r       <= TDIG_RST;
      shown_r      <= DISP_BLANK;
      pf_power_r   <= 1'b0;
      pf_up_r      <= 1'b0;
      pf_down_r    <= 1'b0;
    end else begin
      tdig_r <= tdig_nxt;
      if (adv) begin
        mode_r       <= mode_nxt;
        setpoint_r   <= setpoint_nxt;
        relay_r      <= relay_nxt;
        hold_cnt_r   <= hold_cnt_nxt;
        sample_cnt_r <= sample_cnt_nxt;
        raw_r        <= raw_nxt;
        filt_r       <= filt_nxt;
        shown_r      <= shown_nxt;
        pf_power_r   <= pf_power_nxt;
        pf_up_r      <= pf_up_nxt;
        pf_down_r    <= pf_down_nxt;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (adv) begin
      out_relay_r <= relay_nxt;
      out_mode_r  <= mode_nxt;
      out_disp_r  <= shown_nxt;
      out_beep_r  <= beep_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_relay_on         = out_relay_r;
  assign out_heater_enabled   = out_mode_r;
  assign out_display_blank    = out_disp_r.blank;
  assign out_display_tens     = out_disp_r.tens;
  assign out_display_units    = out_disp_r.units;
  assign out_display_minus    = out_disp_r.minus;
  assign out_showing_setpoint = out_disp_r.setp;
  assign out_beep             = out_beep_r;

`ifndef NO_ASSERTIONS
  // relay can only be energised while the heater is on
  a_relay_needs_mode: assert property (@(posedge clk) disable iff (!rst_n)
    relay_r |-> mode_r)
    else $error("relay on while heater off");

  // display stays blank whenever the heater is off
  a_blank_when_off: assert property (@(posedge clk) disable iff (!rst_n)
    !mode_r |-> shown_r.blank)
    else $error("display lit while heater off");

  // a stepped transaction always shows up as a result next cycle
  a_adv_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid_r && (out_mode_r == mode_r) && (out_relay_r == relay_r))
    else $error("result register out of step with state");

  // setpoint display never carries a minus sign or a blank
  a_setp_clean: assert property (@(posedge clk) disable iff (!rst_n)
    shown_r.setp |-> (!shown_r.minus && !shown_r.blank))
    else $error("setpoint display flags inconsistent");
`endif

endmodule

`default_nettype wire

/* tb/sv/hysteresis_thermostat_controller_core_tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for the thermostat controller core: a tick-level predictor of mode,
// setpoint, relay, filter and display, fed by directed and random button/sensor transactions.
// Depends on htc_pkg and hysteresis_thermostat_controller_core.

module hysteresis_thermostat_controller_core_tb;
  import htc_pkg::*;

  typedef struct {
    logic       relay;
    logic       heater;
    logic       blank;
    logic [5:0] tens;
    logic [3:0] units;
    logic       minus;
    logic       setp;
    logic       beep;
  } tick_out_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_power_button = 1'b0;
  logic                  in_up_button = 1'b0;
  logic                  in_down_button = 1'b0;
  logic [ADC_W-1:0]      in_adc_sample = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_relay_on;
  logic                  out_heater_enabled;
  logic                  out_display_blank;
  logic [TENS_W-1:0]     out_display_tens;
  logic [UNITS_W-1:0]    out_display_units;
  logic                  out_display_minus;
  logic                  out_showing_setpoint;
  logic                  out_beep;

  hysteresis_thermostat_controller_core dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor copy of the registers and state
  logic [3:0] reg_hyst;
  logic [8:0] reg_gain;
  logic [9:0] reg_hold;
  logic [7:0] reg_period;
  logic [5:0] reg_sp_max;
  logic       heat_on, relay, held_power, held_up, held_down;
  logic [5:0] setpoint;
  logic [9:0] hold_cnt;
  logic [7:0] sample_cnt;
  int         raw_q4, filt_q8;
  logic [5:0] temp_tens;
  logic [3:0] temp_units;
  logic       temp_minus;
  disp_t      shown;

  tick_out_t   pending_ticks[$];
  int unsigned mismatches = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned stall_request = 0;

  // random stimulus levels, kept across transactions so buttons are held
  logic btn_power = 1'b0, btn_up = 1'b0, btn_down = 1'b0;
  int   adc_level = 128;

  function automatic void reset_predictor();
    reg_hyst = 4'd1; reg_gain = 9'd77; reg_hold = 10'd300; reg_period = 8'd30;
    reg_sp_max = 6'd40;
    heat_on = 1'b0; setpoint = 6'd22; relay = 1'b0; hold_cnt = '0; sample_cnt = '0;
    raw_q4 = 352; filt_q8 = 5632;
    temp_tens = 6'd2; temp_units = 4'd2; temp_minus = 1'b0;
    shown = '{blank: 1'b1, tens: '0, units: '0, minus: 1'b0, setp: 1'b0};
    held_power = 1'b0; held_up = 1'b0; held_down = 1'b0;
  endfunction

  function automatic tick_out_t thermostat_tick(input logic pw, input logic up,
                                                input logic dn, input logic [7:0] adc);
    tick_out_t res;
    logic      beep;
    int        gain_sat, whole;
    longint    diff, prod;
    beep = 1'b0;
    if (heat_on) begin
      if (hold_cnt < reg_hold) begin
        shown.blank = 1'b0; shown.tens = setpoint / 6'd10; shown.units = 4'(setpoint % 6'd10);
        shown.minus = 1'b0; shown.setp = 1'b1;
        hold_cnt = hold_cnt + 10'd1;
      end else if (!held_up && !held_down) begin
        shown.blank = 1'b0; shown.tens = temp_tens; shown.units = temp_units;
        shown.minus = temp_minus; shown.setp = 1'b0;
      end
      // relay works on the temperature stored at the previous sample
      if (raw_q4 < (int'(setpoint) - int'(reg_hyst)) * 16)
        relay = 1'b1;
      else if (raw_q4 > (int'(setpoint) + int'(reg_hyst)) * 16)
        relay = 1'b0;
      if (sample_cnt < reg_period) begin
        sample_cnt = sample_cnt + 8'd1;
      end else begin
        gain_sat = (reg_gain > 9'd256) ? 256 : int'(reg_gain);
        raw_q4 = int'(adc) * 29 - 832;
        diff = longint'(raw_q4) * 16 - longint'(filt_q8);
        prod = diff * longint'(gain_sat);
        filt_q8 = filt_q8 + int'(prod >>> 8);  // floor division by 256
        whole = filt_q8 / 256;
        if (whole >= 0) begin
          temp_tens = 6'(whole / 10); temp_units = 4'(whole % 10); temp_minus = 1'b0;
        end else if (whole >= -9) begin
          temp_tens = '0; temp_units = 4'(-whole); temp_minus = 1'b1;
        end
        sample_cnt = '0;
        held_up = 1'b0;
        held_down = 1'b0;
      end
      if (up && !held_up) begin
        if (setpoint < reg_sp_max) setpoint = setpoint + 6'd1;
        beep = 1'b1; held_up = 1'b1; hold_cnt = '0;
      end else if (!up && held_up) begin
        held_up = 1'b0;
      end
      // a down press at zero is dropped without a beep or a flag
      if (dn && !held_down) begin
        if (setpoint != 6'd0) begin
          setpoint = setpoint - 6'd1;
          beep = 1'b1; held_down = 1'b1; hold_cnt = '0;
        end
      end else if (!dn && held_down) begin
        held_down = 1'b0;
      end
      if (pw && !held_power) begin
        beep = 1'b1; heat_on = 1'b0; relay = 1'b0; held_power = 1'b1;
        shown = '{blank: 1'b1, tens: '0, units: '0, minus: 1'b0, setp: 1'b0};
      end else if (!pw && held_power) begin
        held_power = 1'b0;
      end
    end else begin
      if (pw && !held_power) begin
        beep = 1'b1; heat_on = 1'b1; relay = 1'b0; held_power = 1'b1;
      end else if (!pw && held_power) begin
        held_power = 1'b0;
      end
    end
    res.relay = relay;
    res.heater = heat_on;
    res.blank = shown.blank;
    res.tens = shown.tens;
    res.units = shown.units;
    res.minus = shown.minus;
    res.setp = shown.setp;
    res.beep = beep;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    if (mismatches < 40)
      $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    tick_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_ticks.size() == 0) begin
        report_mismatch("result with no transaction pending", 8'(out_beep), 8'd0);
      end else begin
        want = pending_ticks.pop_front();
        if (out_relay_on !== want.relay)
          report_mismatch("relay_on", 8'(out_relay_on), 8'(want.relay));
        if (out_heater_enabled !== want.heater)
          report_mismatch("heater_enabled", 8'(out_heater_enabled), 8'(want.heater));
        if (out_display_blank !== want.blank)
          report_mismatch("display_blank", 8'(out_display_blank), 8'(want.blank));
        if (out_display_tens !== want.tens)
          report_mismatch("display_tens", 8'(out_display_tens), 8'(want.tens));
        if (out_display_units !== want.units)
          report_mismatch("display_units", 8'(out_display_units), 8'(want.units));
        if (out_display_minus !== want.minus)
          report_mismatch("display_minus", 8'(out_display_minus), 8'(want.minus));
        if (out_showing_setpoint !== want.setp)
          report_mismatch("showing_setpoint", 8'(out_showing_setpoint), 8'(want.setp));
        if (out_beep !== want.beep) report_mismatch("beep", 8'(out_beep), 8'(want.beep));
      end
    end
  end

  // result side: random stalls, or a long hold-off when one is requested
  initial begin : result_sink
    int unsigned stall;
    forever begin
      if (stall_request != 0) begin
        stall = stall_request;
        stall_request = 0;
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
        @(posedge clk);
      end
    end
  end

  task automatic send_tick(input logic pw, input logic up, input logic dn,
                           input logic [7:0] adc);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_power_button <= pw;
    in_up_button <= up;
    in_down_button <= dn;
    in_adc_sample <= adc;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_ticks.push_back(thermostat_tick(pw, up, dn, adc));
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_ticks.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input int unsigned value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(value);
    @(posedge clk);
    case (idx)
      CFG_HYST:   reg_hyst = 4'(value);
      CFG_GAIN:   reg_gain = 9'(value);
      CFG_HOLD:   reg_hold = 10'(value);
      CFG_PERIOD: reg_period = 8'(value);
      CFG_SP_MAX: reg_sp_max = 6'(value);
      default: ;
    endcase
  endtask

  task automatic apply_settings(input int unsigned hyst, input int unsigned gain,
                                input int unsigned hold, input int unsigned period,
                                input int unsigned sp_max);
    write_reg(CFG_HYST, hyst);
    write_reg(CFG_GAIN, gain);
    write_reg(CFG_HOLD, hold);
    write_reg(CFG_PERIOD, period);
    write_reg(CFG_SP_MAX, sp_max);
    cfg_we <= 1'b0;
  endtask

  task automatic run_random_ticks(input int count);
    for (int n = 0; n < count; n++) begin
      if (btn_power)
        btn_power = ($urandom_range(2) == 0);
      else if (!heat_on)
        btn_power = ($urandom_range(3) == 0);
      else
        btn_power = ($urandom_range(59) == 0);
      if ($urandom_range(7) == 0) btn_up = !btn_up;
      if ($urandom_range(7) == 0) btn_down = !btn_down;
      // mostly a slow drift so the relay band gets crossed, now and then a jump
      if ($urandom_range(4) == 0) begin
        adc_level = $urandom_range(255);
      end else begin
        adc_level = adc_level + int'($urandom_range(16)) - 8;
        if (adc_level < 0) adc_level = 0;
        if (adc_level > 255) adc_level = 255;
      end
      send_tick(btn_power, btn_up, btn_down, 8'(adc_level));
    end
  endtask

  // default registers: power toggling, presses while off and on, held buttons
  task automatic test_power_and_buttons();
    send_tick(1'b0, 1'b0, 1'b0, 8'd100);
    send_tick(1'b0, 1'b1, 1'b0, 8'd100);
    send_tick(1'b1, 1'b0, 1'b0, 8'd100);
    send_tick(1'b1, 1'b0, 1'b0, 8'd100);
    send_tick(1'b0, 1'b1, 1'b0, 8'd120);
    send_tick(1'b0, 1'b1, 1'b0, 8'd120);
    send_tick(1'b0, 1'b0, 1'b1, 8'd120);
    send_tick(1'b0, 1'b0, 1'b0, 8'd0);
    send_tick(1'b1, 1'b0, 1'b0, 8'd255);
    send_tick(1'b0, 1'b0, 1'b0, 8'd255);
    send_tick(1'b1, 1'b1, 1'b1, 8'd50);
    send_tick(1'b0, 1'b0, 1'b0, 8'd50);
  endtask

  // sample every tick at full gain: top of range, below -9, minus sign, zero
  task automatic test_temperature_digits();
    logic [7:0] adc_seq [8] = '{8'd255, 8'd0, 8'd24, 8'd28, 8'd23, 8'd29, 8'd140, 8'd92};
    wait_for_results();
    apply_settings(0, 256, 0, 0, 63);
    foreach (adc_seq[i]) send_tick(1'b0, 1'b0, 1'b0, adc_seq[i]);
  endtask

  // auto-repeat down to zero and up to the limit, then lower the limit below the setpoint
  task automatic test_setpoint_sweep();
    wait_for_results();
    apply_settings(2, 128, 3, 0, 12);
    if (!heat_on) begin
      send_tick(1'b1, 1'b0, 1'b0, 8'd128);
      send_tick(1'b0, 1'b0, 1'b0, 8'd128);
    end
    repeat (26) send_tick(1'b0, 1'b0, 1'b1, 8'($urandom_range(255)));
    repeat (16) send_tick(1'b0, 1'b1, 1'b0, 8'($urandom_range(255)));
    wait_for_results();
    write_reg(CFG_SP_MAX, 5);
    cfg_we <= 1'b0;
    repeat (4) send_tick(1'b0, 1'($urandom_range(1)), 1'b0, 8'($urandom_range(255)));
  endtask

  // long result hold-off so the core fills and stalls its input
  task automatic test_output_backpressure();
    int unsigned saved_idle;
    wait_for_results();
    saved_idle = send_idle_pct;
    send_idle_pct = 0;
    stall_request = 50;
    repeat (12) send_tick(1'b0, 1'($urandom_range(1)), 1'b0, 8'($urandom_range(255)));
    wait_for_results();
    send_idle_pct = saved_idle;
  endtask

  task automatic test_random_phase(input int unsigned hyst, input int unsigned gain,
                                   input int unsigned hold, input int unsigned period,
                                   input int unsigned sp_max, input int count);
    wait_for_results();
    apply_settings(hyst, gain, hold, period, sp_max);
    run_random_ticks(count);
  endtask

  initial begin
    reset_predictor();
    send_idle_pct = 26;
    recv_idle_pct = 80;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_power_and_buttons();
    test_temperature_digits();
    test_setpoint_sweep();
    test_random_phase(1, 77, 300, 30, 40, 110);
    test_random_phase(0, 0, 0, 0, 0, 110);
    test_random_phase(15, 511, 1023, 255, 63, 110);
    test_output_backpressure();
    send_idle_pct = 80;
    recv_idle_pct = 26;
    test_random_phase(3, 256, 5, 2, 30, 110);
    test_random_phase(2, 300, 12, 4, 10, 110);
    test_random_phase($urandom_range(15), $urandom_range(511), $urandom_range(40),
                      $urandom_range(8), $urandom_range(63), 110);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_phase($urandom_range(15), $urandom_range(511), $urandom_range(40),
                      $urandom_range(8), $urandom_range(63), 110);
    test_random_phase(1, 128, 0, 1, 63, 110);
    wait_for_results();
    repeat (5) @(posedge clk);
    if (pending_ticks.size() != 0)
      report_mismatch("results never delivered", 8'd0, 8'(pending_ticks.size()));
    if (mismatches == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

/* hysteresis_thermostat_controller_core.f */
src/htc_pkg.sv
src/hysteresis_thermostat_controller_core.sv
tb/sv/hysteresis_thermostat_controller_core_tb.sv
